// File: sv/lsg_pkg.sv
// shared types, constants and arithmetic helpers for the least-squares gradient core
package lsg_pkg;

    localparam int MAX_FEATURES = 16;
    localparam int LANE_LIMIT   = (MAX_FEATURES < 16) ? MAX_FEATURES : 16;
    localparam int IDX_W        = 4;
    localparam int CNT_W        = 5;
    localparam int VAL_W        = 32;
    localparam int PROD_W       = 2 * VAL_W;
    localparam int RND_W        = PROD_W - 16;
    localparam int ACC_W        = 48;
    localparam int DOT_W        = 52;
    localparam int DIFF_W       = DOT_W + 1;
    localparam int S_TDATA_W    = 40;
    localparam int M_TDATA_W    = 40;

    // input command codes
    typedef enum logic [1:0] {
        CMD_LOAD_WEIGHT = 2'd0,
        CMD_FEATURE     = 2'd1,
        CMD_TARGET      = 2'd2,
        CMD_FINISH      = 2'd3
    } cmd_t;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DOT_MUL,
        S_DOT_RND,
        S_DOT_ADD,
        S_RESID,
        S_GRAD_MUL,
        S_GRAD_RND,
        S_GRAD_ADD,
        S_EMIT_LOAD,
        S_EMIT_WAIT
    } state_t;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [VAL_W-1:0] sat_to32(input logic signed [DIFF_W-1:0] v);
        logic signed [DIFF_W-1:0] hi;
        logic signed [DIFF_W-1:0] lo;
        hi = DIFF_W'(signed'(33'sh0_7FFF_FFFF));
        lo = -hi - DIFF_W'(1);
        if (v > hi)
            return hi[VAL_W-1:0];
        else if (v < lo)
            return lo[VAL_W-1:0];
        else
            return v[VAL_W-1:0];
    endfunction

    // saturate a 49-bit sum to the 48-bit accumulator range
    function automatic logic signed [ACC_W-1:0] sat_to48(input logic signed [ACC_W:0] v);
        if (v[ACC_W] != v[ACC_W-1])
            return v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        else
            return v[ACC_W-1:0];
    endfunction

endpackage

// File: sv/lsg_mul.sv
// shared signed multiplier with round-half-up to q32.16, two register stages
module lsg_mul (
    input  logic                              clk,
    input  logic signed [lsg_pkg::VAL_W-1:0]  op_a,
    input  logic signed [lsg_pkg::VAL_W-1:0]  op_b,
    output logic signed [lsg_pkg::RND_W-1:0]  rnd_q
);
    import lsg_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] bias_sum;
    logic signed [RND_W-1:0]  rnd_reg;
    logic signed [RND_W-1:0]  rnd_next;

    // full q32.32 product
    assign prod_next = PROD_W'(op_a) * PROD_W'(op_b);

    // add half an lsb, then floor by dropping the low 16 bits
    assign bias_sum = prod_reg + PROD_W'(32768);
    assign rnd_next = bias_sum[PROD_W-1:16];

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        rnd_reg  <= rnd_next;
    end

    assign rnd_q = rnd_reg;

endmodule

// File: sv/least_squares_gradient_core.sv
// top level of the least-squares gradient core: sequencer, state arrays and output register
//
//  channel | direction | handshake          | contents
//  s_*     | in        | s_tvalid/s_tready  | tuser command, tdata index and value
//  m_*     | out       | m_tvalid/m_tready  | tdata feature index and gradient, tlast
//  cfg_*   | in        | cfg_we             | feature_count, 5 bits
//
//  weight and feature items are accepted in idle and may follow back to back
//  a target item walks the features with the shared multiplier: once for the
//  dot product and once for the accumulator update, in the steps multiply,
//  round and add per feature, with a residual step between the two walks
//  a finish item loads and offers one result per feature, waiting out any output stall; s_tready is low meanwhile
//  reset clears weights, accumulators and feature_count (to 1) at once
module least_squares_gradient_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [1:0]                       s_tuser,  // command
    input  logic [lsg_pkg::S_TDATA_W-1:0]    s_tdata,  // index[3:0], value[35:4], zero fill
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lsg_pkg::M_TDATA_W-1:0]    m_tdata,  // feature_index[3:0], gradient_value[35:4]
    output logic                             m_tlast,
    input  logic                             cfg_we,
    input  logic [lsg_pkg::CNT_W-1:0]        cfg_data
);
    import lsg_pkg::*;

    state_t                    state_reg;
    state_t                    state_next;
    logic [CNT_W-1:0]          fc_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic [IDX_W-1:0]          idx_next;
    logic [IDX_W-1:0]          last_idx;
    logic [CNT_W-1:0]          lanes;

    logic signed [VAL_W-1:0]   weights_reg  [MAX_FEATURES];
    logic signed [VAL_W-1:0]   features_reg [MAX_FEATURES];
    logic signed [ACC_W-1:0]   acc_reg      [MAX_FEATURES];

    logic signed [DOT_W-1:0]   dot_reg;
    logic signed [VAL_W-1:0]   target_reg;
    logic signed [VAL_W-1:0]   resid_reg;
    logic signed [VAL_W-1:0]   op_a;
    logic signed [VAL_W-1:0]   op_b;
    logic signed [RND_W-1:0]   rnd_q;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [ACC_W:0]     acc_sum;
    logic signed [ACC_W-1:0]   acc_new;

    logic [IDX_W-1:0]          out_idx_reg;
    logic signed [VAL_W-1:0]   out_val_reg;
    logic                      out_last_reg;

    logic                      in_xfer;
    logic                      out_xfer;
    cmd_t                      cmd;
    logic [IDX_W-1:0]          in_idx;
    logic signed [VAL_W-1:0]   in_val;
    logic                      at_last;

    // control strobes from the output decoder
    logic                      dot_clr;
    logic                      dot_add;
    logic                      resid_ld;
    logic                      acc_add;
    logic                      out_ld;
    logic                      acc_clr;

    assign cmd    = cmd_t'(s_tuser);
    assign in_idx = s_tdata[IDX_W-1:0];
    assign in_val = s_tdata[IDX_W+VAL_W-1:IDX_W];

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;

    // features in use: zero acts as one, large values clip to the lane limit
    always_comb
    begin
        if (fc_reg == '0)
            lanes = CNT_W'(1);
        else if (fc_reg > CNT_W'(LANE_LIMIT))
            lanes = CNT_W'(LANE_LIMIT);
        else
            lanes = fc_reg;
    end
    assign last_idx = IDX_W'(lanes - CNT_W'(1));
    assign at_last  = (idx_reg == last_idx);

    // shared multiplier operands
    assign op_a = (state_reg == S_GRAD_MUL) ? resid_reg : weights_reg[idx_reg];
    assign op_b = features_reg[idx_reg];

    lsg_mul u_mul (
        .clk   (clk),
        .op_a  (op_a),
        .op_b  (op_b),
        .rnd_q (rnd_q)
    );

    // residual and accumulator arithmetic
    assign diff    = DIFF_W'(dot_reg) - DIFF_W'(target_reg);
    assign acc_sum = (ACC_W+1)'(acc_reg[idx_reg]) + (ACC_W+1)'(rnd_q);
    assign acc_new = sat_to48(acc_sum);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && cmd == CMD_TARGET)
                    state_next = S_DOT_MUL;
                else if (in_xfer && cmd == CMD_FINISH)
                    state_next = S_EMIT_LOAD;
            end
            S_DOT_MUL:   state_next = S_DOT_RND;
            S_DOT_RND:   state_next = S_DOT_ADD;
            S_DOT_ADD:   state_next = at_last ? S_RESID : S_DOT_MUL;
            S_RESID:     state_next = S_GRAD_MUL;
            S_GRAD_MUL:  state_next = S_GRAD_RND;
            S_GRAD_RND:  state_next = S_GRAD_ADD;
            S_GRAD_ADD:  state_next = at_last ? S_IDLE : S_GRAD_MUL;
            S_EMIT_LOAD: state_next = S_EMIT_WAIT;
            S_EMIT_WAIT:
            begin
                if (m_tready)
                    state_next = out_last_reg ? S_IDLE : S_EMIT_LOAD;
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        dot_clr  = 1'b0;
        dot_add  = 1'b0;
        resid_ld = 1'b0;
        acc_add  = 1'b0;
        out_ld   = 1'b0;
        acc_clr  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                dot_clr  = 1'b1;
            end
            S_DOT_ADD:   dot_add  = 1'b1;
            S_RESID:     resid_ld = 1'b1;
            S_GRAD_ADD:  acc_add  = 1'b1;
            S_EMIT_LOAD: out_ld   = 1'b1;
            S_EMIT_WAIT:
            begin
                m_tvalid = 1'b1;
                acc_clr  = m_tready && out_last_reg;
            end
            default:
            begin
            end
        endcase
    end

    // feature index walk
    always_comb
    begin
        idx_next = idx_reg;
        if (state_reg == S_IDLE)
            idx_next = '0;
        else if (dot_add || acc_add)
            idx_next = at_last ? '0 : idx_reg + IDX_W'(1);
        else if (out_xfer)
            idx_next = idx_reg + IDX_W'(1);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fc_reg    <= CNT_W'(1);
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (cfg_we)
                fc_reg <= cfg_data;
        end
    end

    // weights and accumulators, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_FEATURES; i++)
            begin
                weights_reg[i] <= '0;
                acc_reg[i]     <= '0;
            end
        end
        else
        begin
            if (in_xfer && cmd == CMD_LOAD_WEIGHT && {1'b0, in_idx} < CNT_W'(MAX_FEATURES))
                weights_reg[in_idx] <= in_val;
            if (acc_clr)
            begin
                for (int i = 0; i < MAX_FEATURES; i++)
                    acc_reg[i] <= '0;
            end
            else if (acc_add)
                acc_reg[idx_reg] <= acc_new;
        end
    end

    // sample features and datapath registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_xfer && cmd == CMD_FEATURE && {1'b0, in_idx} < CNT_W'(MAX_FEATURES))
            features_reg[in_idx] <= in_val;
        if (in_xfer && cmd == CMD_TARGET)
            target_reg <= in_val;
        if (dot_clr)
            dot_reg <= '0;
        else if (dot_add)
            dot_reg <= dot_reg + DOT_W'(rnd_q);
        if (resid_ld)
            resid_reg <= sat_to32(diff);
        if (out_ld)
        begin
            out_idx_reg  <= idx_reg;
            out_val_reg  <= sat_to32(DIFF_W'(acc_reg[idx_reg]));
            out_last_reg <= at_last;
        end
    end

    // result channel
    assign m_tdata = {{(M_TDATA_W-IDX_W-VAL_W){1'b0}}, out_val_reg, out_idx_reg};
    assign m_tlast = out_last_reg;

    // no input accepted while a result is offered
    a_no_accept_during_emit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input ready while a result is offered");

    // a finish transfer offers the first result, at feature zero, after the emit load state
    a_finish_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && cmd == CMD_FINISH) |=> ##1 (m_tvalid && m_tdata[IDX_W-1:0] == '0))
        else $error("finish did not start emission at feature zero");

    // the marked result carries the last feature in use
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tdata[IDX_W-1:0] == last_idx))
        else $error("last mark on wrong feature index");

    // a target transfer starts the dot product walk at feature zero
    a_target_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && cmd == CMD_TARGET) |=> (state_reg == S_DOT_MUL && idx_reg == '0))
        else $error("target did not start the dot product walk");

    // the first accumulator is zero after the final result of a batch
    a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && m_tlast) |=> (acc_reg[0] == '0))
        else $error("accumulators not cleared after emission");

endmodule
